### rtl/core/alfs_pkg.sv
// ----------------------------------------------------------------------------
// alfs_pkg
// Shared types and constants for the adaptive line-follow steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package alfs_pkg;

    localparam int unsigned POS_W   = 16;   // Q3.12 position
    localparam int unsigned SPD_W   = 16;   // Q8.8 speed / gain
    localparam int unsigned WT_W    = 13;   // Q1.12 weights
    localparam int unsigned THR_W   = 15;   // Q3.12 magnitudes
    localparam int unsigned OUT_W   = 18;   // Q10.8 wheel speed
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDAT_W  = 16;

    // serial multiplier geometry: radix-4, multiplier consumed two bits a cycle
    localparam int unsigned MCAND_W = 17;
    localparam int unsigned MPLR_W  = 16;
    localparam int unsigned PROD_W  = 36;

    localparam logic [WT_W-1:0] ONE_Q12 = 13'd4096;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;

    typedef enum logic [CIDX_W-1:0] {
        REG_BASE_SPEED   = 3'd0,
        REG_STEER_GAIN   = 3'd1,
        REG_ALPHA_SLOW   = 3'd2,
        REG_ALPHA_FAST   = 3'd3,
        REG_CORNER_THR   = 3'd4,
        REG_DEAD_ZONE    = 3'd5,
        REG_CORNER_RATIO = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [SPD_W-1:0] base_speed;
        logic signed [SPD_W-1:0] steer_gain;
        logic [WT_W-1:0]         alpha_slow;
        logic [WT_W-1:0]         alpha_fast;
        logic [THR_W-1:0]        corner_threshold;
        logic [THR_W-1:0]        dead_zone;
        logic [WT_W-1:0]         corner_scale;
    } t_cfg;

    typedef struct packed {
        logic                      start;
        logic signed [MCAND_W-1:0] mcand;
        logic [MPLR_W-1:0]         mplr;
    } t_mul_req;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] prod;
    } t_mul_rsp;

    // weights above 1.0 are used as 1.0
    function automatic logic [WT_W-1:0] clamp_q12(input logic [WT_W-1:0] w);
        return (w > ONE_Q12) ? ONE_Q12 : w;
    endfunction

endpackage

`default_nettype wire

### rtl/core/alfs_in_if.sv
// ----------------------------------------------------------------------------
// alfs_in_if
// Line-position sample channel: valid/ready with one signed Q3.12 field.
// ----------------------------------------------------------------------------
`default_nettype none

interface alfs_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] line_position;

    modport source (output valid, output line_position, input ready);
    modport sink   (input valid, input line_position, output ready);
endinterface

`default_nettype wire

### rtl/core/alfs_out_if.sv
// ----------------------------------------------------------------------------
// alfs_out_if
// Wheel speed channel: valid/ready with left and right Q10.8 targets.
// ----------------------------------------------------------------------------
`default_nettype none

interface alfs_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] left_speed;
    logic signed [17:0] right_speed;

    modport source (output valid, output left_speed, output right_speed, input ready);
    modport sink   (input valid, input left_speed, input right_speed, output ready);
endinterface

`default_nettype wire

### rtl/core/alfs_cfg.sv
// ----------------------------------------------------------------------------
// alfs_cfg
// Configuration register file: index decode, truncation and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module alfs_cfg
    import alfs_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [CIDX_W-1:0]   i_cfg_idx,
    input  wire  [CDAT_W-1:0]   i_cfg_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_BASE_SPEED:   n_cfg.base_speed       = $signed(i_cfg_data);
                REG_STEER_GAIN:   n_cfg.steer_gain       = $signed(i_cfg_data);
                REG_ALPHA_SLOW:   n_cfg.alpha_slow       = i_cfg_data[WT_W-1:0];
                REG_ALPHA_FAST:   n_cfg.alpha_fast       = i_cfg_data[WT_W-1:0];
                REG_CORNER_THR:   n_cfg.corner_threshold = i_cfg_data[THR_W-1:0];
                REG_DEAD_ZONE:    n_cfg.dead_zone        = i_cfg_data[THR_W-1:0];
                REG_CORNER_RATIO: n_cfg.corner_scale     = i_cfg_data[WT_W-1:0];
                default:          n_cfg = r_cfg;   // unknown index: ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_speed       <= '0;
            r_cfg.steer_gain       <= '0;
            r_cfg.alpha_slow       <= 13'd1229;
            r_cfg.alpha_fast       <= 13'd2867;
            r_cfg.corner_threshold <= 15'd3277;
            r_cfg.dead_zone        <= 15'd1638;
            r_cfg.corner_scale     <= 13'd2253;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/core/alfs_smul.sv
// ----------------------------------------------------------------------------
// alfs_smul
// Radix-4 digit-serial multiplier: signed multiplicand times unsigned
// multiplier, two multiplier bits retired per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module alfs_smul
    import alfs_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire t_mul_req  i_req,
    output t_mul_rsp  o_rsp
);

    localparam int unsigned HI_W  = MCAND_W + 3;
    localparam int unsigned STEPS = MPLR_W / 2;
    localparam int unsigned CNT_W = $clog2(STEPS);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [MCAND_W-1:0] r_mcand;
    logic signed [HI_W-1:0]    r_hi;
    logic [MPLR_W-1:0]         r_lo;

    logic signed [HI_W-1:0]    m_ext;
    logic signed [HI_W-1:0]    pp;
    logic signed [HI_W-1:0]    sum;

    always_comb begin
        m_ext = HI_W'(r_mcand);
        pp    = (r_lo[0] ? m_ext : '0) + (r_lo[1] ? (m_ext <<< 1) : '0);
        sum   = r_hi + pp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mcand <= i_req.mcand;
            r_hi    <= '0;
            r_lo    <= i_req.mplr;
        end else if (r_busy) begin
            r_hi <= sum >>> 2;
            r_lo <= {sum[1:0], r_lo[MPLR_W-1:2]};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = $signed({r_hi, r_lo});

endmodule

`default_nettype wire

### rtl/core/adaptive_line_follow_steering_top.sv
// ----------------------------------------------------------------------------
// adaptive_line_follow_steering_top
// Adaptive EMA line-position filter with dead zone, corner slow-down and
// differential wheel speed output, built around one serial multiplier.
// ----------------------------------------------------------------------------
//  channel   dir  fields                           handshake
//  i_pos     in   line_position  s16 Q3.12         valid/ready
//  o_speed   out  left_speed, right_speed s18 Q10.8 valid/ready
//  cfg       in   i_cfg_idx, i_cfg_data            i_cfg_we, no wait
//
//  One request at a time: three products (filter, corner base, steering)
//  on the shared radix-4 multiplier, plus filter update and output load;
//  the next sample is accepted only after the output load.
//  Reset (sync, active low) clears the filter state and loads register defaults.
//  A result held by a stalled sink blocks only the output load, not the accept.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_line_follow_steering_top
    import alfs_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    alfs_in_if.sink            i_pos,
    alfs_out_if.source         o_speed,
    input  wire                i_cfg_we,
    input  wire  [CIDX_W-1:0]  i_cfg_idx,
    input  wire  [CDAT_W-1:0]  i_cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL_F = 6'b000010,
        ST_FILT  = 6'b000100,
        ST_MUL_B = 6'b001000,
        ST_MUL_D = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_cfg     cfg;
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    t_state r_state;
    t_state n_state;

    logic signed [POS_W-1:0]   r_filt;
    logic                      r_corner;
    logic signed [MCAND_W-1:0] r_dmcand;
    logic [MPLR_W-1:0]         r_dmplr;
    logic signed [SPD_W:0]     r_eb;
    logic signed [19:0]        r_diff;
    logic                      r_ovalid;
    logic signed [OUT_W-1:0]   r_left;
    logic signed [OUT_W-1:0]   r_right;

    logic                      accept;
    logic                      out_load;
    logic signed [POS_W:0]     p_ext;
    logic [POS_W:0]            p_mag;
    logic [WT_W-1:0]           alpha;
    logic signed [MCAND_W-1:0] p_delta;

    logic signed [29:0]        filt_sum;
    logic signed [17:0]        filt_q;
    logic signed [POS_W-1:0]   filt_sat;

    logic signed [POS_W:0]     f_ext;
    logic [POS_W:0]            f_mag;
    logic                      f_dead;
    logic [MPLR_W-1:0]         pos_abs;

    logic signed [29:0]        eb_sum;
    logic signed [32:0]        diff_sum;
    logic signed [20:0]        left_raw;
    logic signed [20:0]        right_raw;

    alfs_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    alfs_smul u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign i_pos.ready = (r_state == ST_IDLE);
    assign accept      = i_pos.valid && i_pos.ready;
    assign out_load    = (r_state == ST_OUT) && (!r_ovalid || o_speed.ready);

    // weight select on the raw sample
    always_comb begin
        p_ext   = (POS_W+1)'(i_pos.line_position);
        p_mag   = p_ext[POS_W] ? (POS_W+1)'(-p_ext) : p_ext;
        if (p_mag >= {2'b00, cfg.corner_threshold}) begin
            alpha = clamp_q12(cfg.alpha_fast);
        end else if (p_mag < {2'b00, cfg.dead_zone}) begin
            alpha = ONE_Q12;
        end else begin
            alpha = clamp_q12(cfg.alpha_slow);
        end
        // a*p + (1-a)*f == a*(p-f) + f
        p_delta = p_ext - (POS_W+1)'(r_filt);
    end

    // filter update: round half up, saturate to 16 bits
    always_comb begin
        filt_sum = mul_rsp.prod[29:0] + 30'($signed({r_filt, 12'b0})) + 30'sd2048;
        filt_q   = filt_sum[29:12];
        if (filt_q > 18'sd32767) begin
            filt_sat = 16'sh7FFF;
        end else if (filt_q < -18'sd32768) begin
            filt_sat = 16'sh8000;
        end else begin
            filt_sat = filt_q[POS_W-1:0];
        end
    end

    // dead zone and corner on the filtered value
    always_comb begin
        f_ext   = (POS_W+1)'(r_filt);
        f_mag   = f_ext[POS_W] ? (POS_W+1)'(-f_ext) : f_ext;
        f_dead  = f_mag < {2'b00, cfg.dead_zone};
        pos_abs = f_mag[MPLR_W-1:0];
    end

    always_comb begin
        eb_sum    = mul_rsp.prod[29:0] + 30'sd2048;
        diff_sum  = mul_rsp.prod[32:0] + 33'sd2048;
        left_raw  = 21'(r_eb) + 21'(r_diff);
        right_raw = 21'(r_eb) - 21'(r_diff);
    end

    always_comb begin
        mul_req = '0;
        case (r_state)
            ST_IDLE: begin
                mul_req.start = accept;
                mul_req.mcand = p_delta;
                mul_req.mplr  = MPLR_W'(alpha);
            end
            ST_FILT: begin
                mul_req.start = 1'b1;
                mul_req.mcand = MCAND_W'(cfg.base_speed);
                mul_req.mplr  = MPLR_W'(clamp_q12(cfg.corner_scale));
            end
            ST_MUL_B: begin
                mul_req.start = mul_rsp.done;
                mul_req.mcand = r_dmcand;
                mul_req.mplr  = r_dmplr;
            end
            default: mul_req = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (accept)       n_state = ST_MUL_F;
            ST_MUL_F: if (mul_rsp.done) n_state = ST_FILT;
            ST_FILT:                    n_state = ST_MUL_B;
            ST_MUL_B: if (mul_rsp.done) n_state = ST_MUL_D;
            ST_MUL_D: if (mul_rsp.done) n_state = ST_OUT;
            ST_OUT:   if (out_load)     n_state = ST_IDLE;
            default:                    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_filt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_MUL_F) && mul_rsp.done) begin
                r_filt <= filt_sat;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_speed.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FILT) begin
            r_corner <= f_mag >= {2'b00, cfg.corner_threshold};
            // sign folded into the multiplicand so the multiplier stays unsigned
            if (f_dead) begin
                r_dmcand <= '0;
                r_dmplr  <= '0;
            end else begin
                r_dmcand <= f_ext[POS_W] ? -MCAND_W'(cfg.steer_gain)
                                         :  MCAND_W'(cfg.steer_gain);
                r_dmplr  <= pos_abs;
            end
        end
        if ((r_state == ST_MUL_B) && mul_rsp.done) begin
            r_eb <= r_corner ? eb_sum[28:12] : (SPD_W+1)'(cfg.base_speed);
        end
        if ((r_state == ST_MUL_D) && mul_rsp.done) begin
            r_diff <= diff_sum[31:12];
        end
        if (out_load) begin
            r_left  <= (left_raw  > 21'(OUT_MAX)) ? OUT_MAX :
                       (left_raw  < 21'(OUT_MIN)) ? OUT_MIN : left_raw[OUT_W-1:0];
            r_right <= (right_raw > 21'(OUT_MAX)) ? OUT_MAX :
                       (right_raw < 21'(OUT_MIN)) ? OUT_MIN : right_raw[OUT_W-1:0];
        end
    end

    assign o_speed.valid       = r_ovalid;
    assign o_speed.left_speed  = r_left;
    assign o_speed.right_speed = r_right;

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for adaptive_line_follow_steering_top. A directed table
// covers register extremes, weight clamping, an inverted dead zone and an
// unmapped register index. Random phases follow, each with its own register
// settings. Expected wheel speeds come from the table for checked rows and
// otherwise from an in-bench model of the filter; they are compared with
// every accepted response, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import alfs_pkg::*;

    localparam logic [CIDX_W-1:0] REG_NONE = 3'd7;  // no register at this index
    localparam int PHASES          = 14;
    localparam int PHASE_ITEMS     = 50;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 3000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int MAX_SHOWN       = 10;

    typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_CHECKED} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CIDX_W-1:0]       idx;
        logic [CDAT_W-1:0]       value;     // register data or sample
        logic signed [OUT_W-1:0] left_speed;
        logic signed [OUT_W-1:0] right_speed;
    } step_row_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] left_speed;
        logic signed [OUT_W-1:0] right_speed;
    } wheel_pair_t;

    typedef struct {
        logic signed [SPD_W-1:0] base_speed;
        logic signed [SPD_W-1:0] steer_gain;
        logic [WT_W-1:0]         alpha_slow;
        logic [WT_W-1:0]         alpha_fast;
        logic [THR_W-1:0]        corner_thr;
        logic [THR_W-1:0]        dead_zone;
        logic [WT_W-1:0]         corner_ratio;
    } steer_setup_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CIDX_W-1:0]  i_cfg_idx;
    logic [CDAT_W-1:0]  i_cfg_data;

    alfs_in_if  pos_ch();
    alfs_out_if speed_ch();

    adaptive_line_follow_steering_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pos      (pos_ch),
        .o_speed    (speed_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    steer_setup_t          setup_m;
    logic signed [POS_W-1:0] filt_m;
    logic signed [POS_W-1:0] track_pos;
    wheel_pair_t           speed_q[$];
    step_row_t             directed_rows[0:41];
    int                    error_cnt    = 0;
    int                    quiet_cycles = 0;
    bit                    idle_on      = 1'b1;
    bit                    hold_off_req = 1'b0;

    // ------------------------------------------------------------------ model

    function automatic longint weight_q12(input logic [WT_W-1:0] w);
        return (w > ONE_Q12) ? longint'(ONE_Q12) : longint'(w);
    endfunction

    // divide by 4096, ties toward +inf
    function automatic longint half_up_q12(input longint v);
        return (v + 2048) >>> 12;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic wheel_pair_t steer_predict(input logic signed [POS_W-1:0] pos);
        longint      p, mag, wt, fp, fmag, used, eb, diff;
        wheel_pair_t res;
        p   = pos;
        mag = (p < 0) ? -p : p;
        // corner test wins even when the dead zone is wider
        if (mag >= longint'(setup_m.corner_thr))
            wt = weight_q12(setup_m.alpha_fast);
        else if (mag < longint'(setup_m.dead_zone))
            wt = longint'(ONE_Q12);
        else
            wt = weight_q12(setup_m.alpha_slow);
        fp = half_up_q12(wt * p + (longint'(ONE_Q12) - wt) * longint'(filt_m));
        fp = clip(fp, -32768, 32767);
        filt_m = POS_W'(fp);
        fmag = (fp < 0) ? -fp : fp;
        used = (fmag < longint'(setup_m.dead_zone)) ? 0 : fp;
        if (fmag >= longint'(setup_m.corner_thr))
            eb = half_up_q12(longint'(setup_m.base_speed) * weight_q12(setup_m.corner_ratio));
        else
            eb = longint'(setup_m.base_speed);
        diff = half_up_q12(longint'(setup_m.steer_gain) * used);
        res.left_speed  = OUT_W'(clip(eb + diff, longint'(OUT_MIN), longint'(OUT_MAX)));
        res.right_speed = OUT_W'(clip(eb - diff, longint'(OUT_MIN), longint'(OUT_MAX)));
        return res;
    endfunction

    // --------------------------------------------------------------- drivers

    function automatic int draw_gap();
        return idle_on ? int'($urandom_range(11, 0)) : 0;
    endfunction

    function automatic logic [CDAT_W-1:0] draw_reg_value(input logic [CIDX_W-1:0] idx);
        int                roll;
        logic [CDAT_W-1:0] v;
        roll = $urandom_range(9, 0);
        v    = CDAT_W'($urandom);
        case (idx)
            REG_BASE_SPEED: begin
                if (roll < 2)      v = roll[0] ? 16'h7FFF : 16'h8000;
                else if (roll < 7) v = CDAT_W'($urandom_range(6000, 0) - 3000);
            end
            REG_STEER_GAIN: begin
                if (roll < 2)      v = roll[0] ? 16'h7FFF : 16'h8000;
                else if (roll < 7) v = CDAT_W'($urandom_range(4000, 0) - 2000);
            end
            REG_CORNER_THR: begin
                if (roll == 0)      v = 16'h0000;
                else if (roll == 1) v = 16'h7FFF;
                else                v = CDAT_W'($urandom_range(12000, 300));
                if ($urandom_range(3, 0) == 0) v[15] = 1'b1;   // ignored bit
            end
            REG_DEAD_ZONE: begin
                if (roll == 0)      v = 16'h0000;
                else if (roll == 1) v = 16'h7FFF;
                else                v = CDAT_W'($urandom_range(4000, 0));
                if ($urandom_range(3, 0) == 0) v[15] = 1'b1;
            end
            default: begin
                // smoothing weights and corner ratio
                if (roll == 0)      v = 16'h0000;
                else if (roll == 1) v = CDAT_W'(ONE_Q12);
                else if (roll == 2) v = CDAT_W'($urandom_range(8191, 4097));
                else                v = CDAT_W'($urandom_range(4096, 0));
                if ($urandom_range(3, 0) == 0) v[15:13] = 3'($urandom);
            end
        endcase
        return v;
    endfunction

    function automatic logic signed [POS_W-1:0] draw_position();
        int roll, m;
        roll = $urandom_range(9, 0);
        case (roll)
            0: begin
                case ($urandom_range(4, 0))
                    0:       m = -32768;
                    1:       m = 32767;
                    2:       m = -32767;
                    3:       m = -1;
                    default: m = 0;
                endcase
            end
            1: begin
                // straddle a threshold
                m = ($urandom_range(1, 0) ? int'(setup_m.corner_thr) : int'(setup_m.dead_zone))
                    + int'($urandom_range(2, 0)) - 1;
                if ($urandom_range(1, 0)) m = -m;
            end
            2, 3, 4: m = int'(POS_W'($urandom)) - 32768;
            5, 6, 7: m = int'(track_pos) + int'($urandom_range(3000, 0)) - 1500;
            default: m = int'($urandom_range(12000, 0)) - 6000;
        endcase
        m = (m > 32767) ? 32767 : ((m < -32768) ? -32768 : m);
        track_pos = POS_W'(m);
        return POS_W'(m);
    endfunction

    task automatic report_error(input string msg);
        error_cnt++;
        if (error_cnt <= MAX_SHOWN) $display("%s", msg);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_BASE_SPEED:   setup_m.base_speed   = data;
            REG_STEER_GAIN:   setup_m.steer_gain   = data;
            REG_ALPHA_SLOW:   setup_m.alpha_slow   = data[WT_W-1:0];
            REG_ALPHA_FAST:   setup_m.alpha_fast   = data[WT_W-1:0];
            REG_CORNER_THR:   setup_m.corner_thr   = data[THR_W-1:0];
            REG_DEAD_ZONE:    setup_m.dead_zone    = data[THR_W-1:0];
            REG_CORNER_RATIO: setup_m.corner_ratio = data[WT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (speed_q.size() != 0) @(posedge i_clk);
    endtask

    // returns at the edge that took the request, with its predicted response
    task automatic feed_sample(input logic signed [POS_W-1:0] pos, input int gap,
                               output wheel_pair_t want);
        if (gap > 0) begin
            pos_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pos_ch.valid         <= 1'b1;
        pos_ch.line_position <= pos;
        do @(posedge i_clk); while (!pos_ch.ready);
        want = steer_predict(pos);
    endtask

    // --------------------------------------------------------------- checking

    always @(posedge i_clk) begin : speed_check
        wheel_pair_t want;
        if (i_rst_n && speed_ch.valid && speed_ch.ready) begin
            if (speed_q.size() == 0) begin
                report_error($sformatf("unexpected response: left %0d right %0d",
                                       speed_ch.left_speed, speed_ch.right_speed));
            end else begin
                want = speed_q.pop_front();
                if (speed_ch.left_speed !== want.left_speed)
                    report_error($sformatf("left_speed: expected %0d, got %0d",
                                           want.left_speed, speed_ch.left_speed));
                if (speed_ch.right_speed !== want.right_speed)
                    report_error($sformatf("right_speed: expected %0d, got %0d",
                                           want.right_speed, speed_ch.right_speed));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pos_ch.valid && pos_ch.ready) || (speed_ch.valid && speed_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ----------------------------------------------------------- sink side

    initial begin : sink_side
        int hold;
        speed_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold         = HOLD_OFF_CYCLES;    // let the block back up
            end else begin
                hold = draw_gap();
            end
            if (hold > 0) begin
                speed_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            speed_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!speed_ch.valid);
        end
    end

    // ----------------------------------------------------------- main flow

    initial begin : main_flow
        wheel_pair_t want;
        step_row_t   row;
        int          phase, n, r;

        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= REG_BASE_SPEED;
        i_cfg_data           <= '0;
        pos_ch.valid         <= 1'b0;
        pos_ch.line_position <= '0;

        setup_m   = '{16'sd0, 16'sd0, 13'd1229, 13'd2867, 15'd3277, 15'd1638, 13'd2253};
        filt_m    = '0;
        track_pos = '0;

        directed_rows = '{
            // defaults: zero base and gain give zero speeds
            '{ROW_CHECKED, REG_NONE,         16'h0000, 18'sd0, 18'sd0},
            '{ROW_CHECKED, REG_NONE,         16'h7FFF, 18'sd0, 18'sd0},
            '{ROW_CHECKED, REG_NONE,         16'h8000, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_BASE_SPEED,   16'h7FFF, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_STEER_GAIN,   16'h0100, 18'sd0, 18'sd0},
            '{ROW_CHECKED, REG_NONE,         16'h0000, 18'sd32767, 18'sd32767},
            '{ROW_SAMPLE,  REG_NONE,         16'd2000, 18'sd0, 18'sd0},
            '{ROW_SAMPLE,  REG_NONE,         16'd5000, 18'sd0, 18'sd0},
            '{ROW_SAMPLE,  REG_NONE,         16'hEC78, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_BASE_SPEED,   16'h8000, 18'sd0, 18'sd0},
            '{ROW_CHECKED, REG_NONE,         16'h0000, -18'sd32768, -18'sd32768},
            // weights above one, unused high data bits
            '{ROW_WRITE,   REG_ALPHA_SLOW,   16'h1FFF, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_ALPHA_FAST,   16'hFFFF, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_CORNER_THR,   16'hFFFF, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_DEAD_ZONE,    16'h0000, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_CORNER_RATIO, 16'h1000, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_BASE_SPEED,   16'h7FFF, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_STEER_GAIN,   16'h7FFF, 18'sd0, 18'sd0},
            // full-scale position saturates both wheels
            '{ROW_CHECKED, REG_NONE,         16'h7FFF, OUT_MAX, OUT_MIN},
            '{ROW_CHECKED, REG_NONE,         16'h8000, OUT_MIN, OUT_MAX},
            '{ROW_SAMPLE,  REG_NONE,         16'h0001, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_STEER_GAIN,   16'h8000, 18'sd0, 18'sd0},
            '{ROW_SAMPLE,  REG_NONE,         16'h7FFF, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_CORNER_RATIO, 16'h1FFF, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_CORNER_THR,   16'h0000, 18'sd0, 18'sd0},
            '{ROW_SAMPLE,  REG_NONE,         16'hFFFF, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_CORNER_RATIO, 16'h0000, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_STEER_GAIN,   16'h0000, 18'sd0, 18'sd0},
            '{ROW_CHECKED, REG_NONE,         16'h0064, 18'sd0, 18'sd0},
            // dead zone wider than the corner threshold
            '{ROW_WRITE,   REG_ALPHA_SLOW,   16'h0000, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_ALPHA_FAST,   16'h0000, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_DEAD_ZONE,    16'h7FFF, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_CORNER_THR,   16'd1000, 18'sd0, 18'sd0},
            '{ROW_SAMPLE,  REG_NONE,         16'd500,  18'sd0, 18'sd0},
            '{ROW_SAMPLE,  REG_NONE,         16'd20000, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_ALPHA_FAST,   16'h0001, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_BASE_SPEED,   16'd12345, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_STEER_GAIN,   16'd1000, 18'sd0, 18'sd0},
            '{ROW_WRITE,   REG_CORNER_RATIO, 16'h0800, 18'sd0, 18'sd0},
            '{ROW_SAMPLE,  REG_NONE,         16'hB1E0, 18'sd0, 18'sd0},
            // write to an unmapped index must change nothing
            '{ROW_WRITE,   REG_NONE,         16'hFFFF, 18'sd0, 18'sd0},
            '{ROW_SAMPLE,  REG_NONE,         16'h1234, 18'sd0, 18'sd0}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_WRITE) begin
                pos_ch.valid <= 1'b0;
                drain();
                write_reg(row.idx, row.value);
            end else begin
                i_cfg_we <= 1'b0;
                feed_sample(row.value, draw_gap(), want);
                if (row.kind == ROW_CHECKED)
                    speed_q.push_back('{row.left_speed, row.right_speed});
                else
                    speed_q.push_back(want);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            pos_ch.valid <= 1'b0;
            drain();
            for (r = 0; r <= int'(REG_CORNER_RATIO); r++)
                write_reg(CIDX_W'(r), draw_reg_value(CIDX_W'(r)));
            if ($urandom_range(3, 0) == 0) write_reg(REG_NONE, CDAT_W'($urandom));
            i_cfg_we <= 1'b0;
            idle_on = (phase % 4 != 2);
            if (phase == 3) hold_off_req = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 8 && n == PHASE_ITEMS / 2) begin
                    // sender waits for every response before going on
                    pos_ch.valid <= 1'b0;
                    drain();
                end
                feed_sample(draw_position(), draw_gap(), want);
                speed_q.push_back(want);
            end
        end

        pos_ch.valid <= 1'b0;
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_cnt == 0 && speed_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
